>>> rtl/core/dsq_pkg.sv
// shared types and constants for the deadline sleep queue
// no dependencies
package dsq_pkg;

    localparam int DL_W        = 63;
    localparam int TICKS_W     = 32;
    localparam int KIND_W      = 3;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    typedef logic [DL_W-1:0]    t_deadline;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [TICKS_W-1:0] t_ticks;

    localparam t_kind KIND_QUEUED  = 3'd0;
    localparam t_kind KIND_NO_WAIT = 3'd1;
    localparam t_kind KIND_FULL    = 3'd2;
    localparam t_kind KIND_WOKEN   = 3'd3;
    localparam t_kind KIND_NONE    = 3'd4;

    // a lookahead read is allowed while the current wake number stays below this
    localparam t_count LA_LIMIT = t_count'(MAX_RESULTS - 1);

endpackage

>>> rtl/core/dsq_mem.sv
// entry store: one write port, one read port with registered read data
// no dependencies
module dsq_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 71,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/deadline_sleep_queue.sv
// Tick counter with a deadline-ordered queue of sleeping threads, kept as a ring in one
// memory with a single read port. A sleep beat that needs no wait or finds the queue
// full is answered without a memory access. A queued sleep scans down from the tail,
// moving each queued entry with a later deadline one slot up, until an entry stays in
// place and ends the scan or every entry has moved; then the new entry is written. A tick
// beat advances the count and wakes the due threads from the head (at most 16 per beat),
// reading each next entry ahead of the result it emits; an empty queue or one with
// nothing due yields a single none result. Results leave through an output register,
// and a stalled output holds the wake sweep and every result.
// Depends on dsq_pkg and dsq_mem.
module deadline_sleep_queue #(
    parameter int WAITERS        = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [THREAD_ID_BITS-1:0]       i_thread_id,
    input  logic signed [dsq_pkg::TICKS_W-1:0] i_sleep_ticks,
    output logic                            o_valid,
    input  logic                            i_ready,
    output dsq_pkg::t_kind                  o_kind,
    output logic [THREAD_ID_BITS-1:0]       o_woken_id,
    output dsq_pkg::t_deadline              o_now_ticks,
    output logic                            o_last
);

    localparam int IW    = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int UW    = $clog2(WAITERS + 1);
    localparam int ENT_W = dsq_pkg::DL_W + THREAD_ID_BITS;
    localparam logic [IW:0] DEPTH_V = (IW + 1)'(WAITERS);
    localparam logic [UW-1:0] FULL_V = UW'(WAITERS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCMP  = 3'd2;
    localparam logic [2:0] ST_SPUT  = 3'd3;
    localparam logic [2:0] ST_T0    = 3'd4;
    localparam logic [2:0] ST_TW    = 3'd5;
    localparam logic [2:0] ST_TNONE = 3'd6;

    function automatic logic [IW-1:0] f_phys(input logic [IW-1:0] h, input logic [IW-1:0] l);
        logic [IW:0] s;
        s = {1'b0, h} + {1'b0, l};
        if (s >= DEPTH_V) begin
            s = s - DEPTH_V;
        end
        return s[IW-1:0];
    endfunction

    logic [2:0]                r_state, n_state;
    logic [UW-1:0]             r_used, n_used;
    logic [IW-1:0]             r_head, n_head;
    logic [IW-1:0]             r_pos, n_pos;
    dsq_pkg::t_count           r_cnt, n_cnt;
    logic                      r_la, n_la;
    logic [THREAD_ID_BITS-1:0] r_cur, n_cur;
    dsq_pkg::t_deadline        r_tick, n_tick;
    dsq_pkg::t_deadline        r_dl, n_dl;
    logic                      r_func;
    logic [THREAD_ID_BITS-1:0] r_id;
    dsq_pkg::t_ticks           r_ticks;

    logic                      r_ovalid;
    dsq_pkg::t_kind            r_okind;
    logic [THREAD_ID_BITS-1:0] r_oid;
    dsq_pkg::t_deadline        r_onow;
    logic                      r_olast;

    logic                      emit;
    dsq_pkg::t_kind            e_kind;
    logic [THREAD_ID_BITS-1:0] e_id;
    logic                      e_last;

    logic                      wr_en, rd_en;
    logic [IW-1:0]             wr_addr, rd_addr;
    logic [ENT_W-1:0]          wr_data, rd_data;

    logic                      accept, out_free;
    logic [63:0]               dl_sum;
    dsq_pkg::t_deadline        dl_sat;
    dsq_pkg::t_deadline        rd_dl;
    logic [THREAD_ID_BITS-1:0] rd_id;
    logic                      rd_due;
    logic [UW-1:0]             used_m1;
    logic [IW-1:0]             head_inc;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == ST_IDLE);

    assign dl_sum   = {1'b0, r_tick} + {33'b0, r_ticks[dsq_pkg::TICKS_W-2:0]};
    assign dl_sat   = dl_sum[63] ? '1 : dl_sum[62:0];
    assign rd_dl    = rd_data[ENT_W-1 -: dsq_pkg::DL_W];
    assign rd_id    = rd_data[THREAD_ID_BITS-1:0];
    assign rd_due   = (rd_dl <= r_tick);
    assign used_m1  = r_used - 1'b1;
    assign head_inc = f_phys(r_head, IW'(1));

    dsq_mem #(
        .DEPTH  (WAITERS),
        .WIDTH  (ENT_W),
        .ADDR_W (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        n_used  = r_used;
        n_head  = r_head;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_la    = r_la;
        n_cur   = r_cur;
        n_tick  = r_tick;
        n_dl    = r_dl;
        wr_en   = 1'b0;
        wr_addr = f_phys(r_head, r_pos);
        wr_data = {r_dl, r_id};
        rd_en   = 1'b0;
        rd_addr = r_head;
        emit    = 1'b0;
        e_kind  = dsq_pkg::KIND_QUEUED;
        e_id    = r_id;
        e_last  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (r_func) begin
                    n_tick = r_tick + 1'b1;
                    if (r_used == '0) begin
                        n_state = ST_TNONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_head;
                        n_state = ST_T0;
                    end
                end else if (r_ticks == '0 || r_ticks[dsq_pkg::TICKS_W-1]) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_kind  = dsq_pkg::KIND_NO_WAIT;
                        n_state = ST_IDLE;
                    end
                end else if (r_used == FULL_V) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_kind  = dsq_pkg::KIND_FULL;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_dl  = dl_sat;
                    n_pos = r_used[IW-1:0];
                    if (r_used == '0) begin
                        n_state = ST_SPUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = f_phys(r_head, used_m1[IW-1:0]);
                        n_state = ST_SCMP;
                    end
                end
            end
            ST_SCMP: begin
                if (rd_dl > r_dl) begin
                    wr_en   = 1'b1;
                    wr_addr = f_phys(r_head, r_pos);
                    wr_data = rd_data;
                    n_pos   = r_pos - 1'b1;
                    if (r_pos > IW'(1)) begin
                        rd_en   = 1'b1;
                        rd_addr = f_phys(r_head, r_pos - IW'(2));
                    end else begin
                        n_state = ST_SPUT;
                    end
                end else begin
                    n_state = ST_SPUT;
                end
            end
            ST_SPUT: begin
                if (out_free) begin
                    wr_en   = 1'b1;
                    wr_addr = f_phys(r_head, r_pos);
                    wr_data = {r_dl, r_id};
                    n_used  = r_used + 1'b1;
                    emit    = 1'b1;
                    e_kind  = dsq_pkg::KIND_QUEUED;
                    n_state = ST_IDLE;
                end
            end
            ST_T0: begin
                if (rd_due) begin
                    n_cur = rd_id;
                    n_cnt = dsq_pkg::t_count'(1);
                    n_la  = (r_used > 1);
                    if (r_used > 1) begin
                        rd_en   = 1'b1;
                        rd_addr = head_inc;
                    end
                    n_state = ST_TW;
                end else begin
                    n_state = ST_TNONE;
                end
            end
            ST_TW: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = dsq_pkg::KIND_WOKEN;
                    e_id   = r_cur;
                    e_last = !(r_la && rd_due);
                    n_head = head_inc;
                    n_used = r_used - 1'b1;
                    if (r_la && rd_due) begin
                        n_cur = rd_id;
                        n_cnt = r_cnt + 1'b1;
                        n_la  = (r_used > 2) && (r_cnt < dsq_pkg::LA_LIMIT);
                        if ((r_used > 2) && (r_cnt < dsq_pkg::LA_LIMIT)) begin
                            rd_en   = 1'b1;
                            rd_addr = f_phys(head_inc, IW'(1));
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TNONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = dsq_pkg::KIND_NONE;
                    e_id    = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_head   <= '0;
            r_tick   <= '0;
            r_ovalid <= 1'b0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_la     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_head  <= n_head;
            r_tick  <= n_tick;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_la    <= n_la;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_dl  <= n_dl;
        if (accept) begin
            r_func  <= i_func;
            r_id    <= i_thread_id;
            r_ticks <= i_sleep_ticks;
        end
        if (emit) begin
            r_okind <= e_kind;
            r_oid   <= e_id;
            r_onow  <= r_tick;
            r_olast <= e_last;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_kind      = r_okind;
    assign o_woken_id  = r_oid;
    assign o_now_ticks = r_onow;
    assign o_last      = r_olast;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_V)
        else $error("queue fill beyond capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en && (wr_addr == rd_addr)))
        else $error("read and write of the same entry in one cycle");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START && r_func) |=> (r_tick == $past(r_tick) + 1'b1))
        else $error("tick beat did not advance the count");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_ovalid || i_ready))
        else $error("result overwrote a pending beat");

endmodule
